### src/assert_macros.svh
// Assertion macros shared by the pulse fitter RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/pat_pkg.sv
// Package for the pulse amplitude/time fitter: payload types, codes, constants.
// No dependencies.
package pat_pkg;

    // sizes
    localparam int MAX_SAMPLES = 64;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int FIT_POINTS  = 6;
    localparam int NP_W        = $clog2(FIT_POINTS + 1);

    // arithmetic widths
    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;
    localparam int DIV_W  = 48;
    localparam int DVS_W  = 32;

    // fixed levels
    localparam logic [9:0]         OVF_LEVEL     = 10'd900;
    localparam logic [9:0]         MIN_TIMED_AMP = 10'd10;
    localparam logic signed [15:0] NO_TIME_Q88   = -16'sd512;
    localparam int                 TIME_OFFSET   = 7 * 256;

    // result status codes
    localparam logic [2:0] STAT_OK      = 3'd0;
    localparam logic [2:0] STAT_EMPTY   = 3'd1;
    localparam logic [2:0] STAT_BAD_PED = 3'd2;
    localparam logic [2:0] STAT_NO_TIME = 3'd3;
    localparam logic [2:0] STAT_OVF     = 3'd4;

    // configuration register indexes
    localparam logic [1:0] CFG_PED_EN    = 2'd0;
    localparam logic [1:0] CFG_PRESAMPLE = 2'd1;
    localparam logic [1:0] CFG_AMP_FLOOR = 2'd2;

    typedef struct packed {
        logic [9:0] sample_value;
        logic       sample_present;
        logic       last_sample;
    } t_in_item;

    typedef struct packed {
        logic [9:0]         amplitude;
        logic signed [15:0] pulse_time;
        logic               overflow_seen;
        logic [2:0]         fit_status;
    } t_out_item;

endpackage

### src/pulse_amplitude_time_fitter.sv
// Pulse amplitude and leading-edge time fitter, top level.
// Depends on pat_pkg, pat_divider and assert_macros.svh.
//
//   channel   direction  handshake                   payload
//   input     in         i_valid / o_stall           i_item  (t_in_item)
//   result    out        o_valid / i_stall           o_item  (t_out_item)
//   config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Samples load one per cycle, while o_stall is low, into a 64-entry sample
// RAM. The item with last_sample starts evaluation: the edge scan walks back
// over the samples, the fit accumulates each point on the shared 24x24
// multiplier, the line crossing is formed from the sums, and the restoring
// divider produces the time. o_stall stays high for the whole evaluation and
// until the result register is free. Reset is synchronous.
module pulse_amplitude_time_fitter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  pat_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output pat_pkg::t_out_item o_item,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [9:0]         i_cfg_data
);
    import pat_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [4:0] {
        ST_LOAD, ST_EVAL, ST_SCAN, ST_SCAN_CHK,
        ST_FIT_SEL, ST_FIT_MXY, ST_FIT_MXX, ST_FIT_ACC, ST_FIT_CHK,
        ST_DET1, ST_DET2, ST_DET3, ST_SLP,
        ST_NUM1, ST_NUM2, ST_NUM3, ST_NUM4, ST_NUM5,
        ST_DEN, ST_DIV, ST_FIN, ST_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic       r_ped_en;
    logic [6:0] r_presample;
    logic [9:0] r_floor;

    // pulse state
    logic [CNT_W-1:0] r_count;
    logic [9:0]       r_peak;
    logic [6:0]       r_rep;
    logic [6:0]       r_ped_seen;

    // sample RAM
    logic [9:0]        r_mem [MAX_SAMPLES];
    logic [9:0]        r_rd;
    logic [ADDR_W-1:0] n_raddr;

    // evaluation registers
    logic [9:0]        r_amp;
    logic              r_ovf;
    logic [CNT_W-1:0]  r_pos;
    logic signed [7:0] r_up;
    logic [CNT_W-1:0]  r_dn;
    logic [NP_W-1:0]   r_np;
    logic              r_phase_b;
    logic [ADDR_W-1:0] r_idx;
    logic [ADDR_W-1:0] r_x;
    logic [9:0]        r_y;
    logic [8:0]        r_sx;
    logic [12:0]       r_sy;
    logic [14:0]       r_sxx;
    logic [18:0]       r_sxy;
    logic signed [MUL_W-1:0]  r_tmp;
    logic signed [MUL_W-1:0]  r_det;
    logic signed [MUL_W-1:0]  r_slope;
    logic signed [MUL_W-1:0]  r_t1;
    logic signed [PROD_W-1:0] r_num;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_neg;

    // result
    logic signed [15:0] r_res_time;
    logic [2:0]         r_res_status;
    t_out_item          r_out;
    logic               r_out_valid;

    // combinational helpers
    logic                     n_accept;
    logic                     n_store;
    logic signed [MUL_W-1:0]  n_mul_a;
    logic signed [MUL_W-1:0]  n_mul_b;
    logic [ADDR_W-1:0]        n_x;
    logic [14:0]              n_s20;
    logic [14:0]              n_a7;
    logic [12:0]              n_amp7;
    logic [17:0]              n_sy20;
    logic [13:0]              n_sx20;
    logic [MUL_W-1:0]         n_np20;
    logic signed [MUL_W-1:0]  n_slope;
    logic [9:0]               n_amp;
    logic                     n_ovf;
    logic signed [PROD_W-1:0] n_den;
    logic signed [PROD_W-1:0] n_num;
    logic [PROD_W-1:0]        n_mag;
    logic                     n_div_start;
    logic [DIV_W-1:0]         n_dividend;
    logic [DVS_W-1:0]         n_divisor;
    logic                     w_div_done;
    logic [DIV_W-1:0]         w_quot;
    logic signed [DIV_W+1:0]  n_q;

    assign n_accept = i_valid && !o_stall;
    assign n_store  = n_accept && i_item.sample_present && (r_count < CNT_W'(MAX_SAMPLES));

    // constant scalings
    assign n_x    = ADDR_W'(r_count - CNT_W'(r_idx) - 1'b1);
    assign n_s20  = 15'(r_rd) * 15'd20;
    assign n_amp7 = 13'(r_amp) * 13'd7;
    assign n_a7   = 15'(n_amp7);
    assign n_sy20 = 18'(r_sy) * 18'd20;
    assign n_sx20 = 14'(r_sx) * 14'd20;
    assign n_np20 = MUL_W'(r_np) * MUL_W'(20);
    assign n_slope = r_tmp - MUL_W'(r_prod);

    // amplitude and overflow from the loaded pulse
    assign n_ovf = (r_peak > OVF_LEVEL) && (r_rep > 7'd2);
    assign n_amp = (r_peak < r_floor) ? 10'd0 : r_peak;

    // denominator sign normalization ahead of the divider
    always_comb begin
        n_den = r_prod;
        n_num = r_num;
        if (r_prod < 0) begin
            n_den = -r_prod;
            n_num = -r_num;
        end
        n_mag       = (n_num < 0) ? PROD_W'(-n_num) : PROD_W'(n_num);
        n_dividend  = DIV_W'((n_mag << 9) + PROD_W'(n_den));
        n_divisor   = DVS_W'(n_den << 1);
        n_div_start = (r_state == ST_DEN);
    end

    // shared multiplier operand select and read address
    always_comb begin
        n_mul_a = '0;
        n_mul_b = '0;
        n_raddr = ADDR_W'(r_pos - 1'b1);
        unique case (r_state)
            ST_FIT_SEL: n_raddr = r_phase_b ? ADDR_W'(r_dn) : ADDR_W'(r_up);
            ST_FIT_MXY: begin
                n_mul_a = MUL_W'(n_x);
                n_mul_b = MUL_W'(r_rd);
            end
            ST_FIT_MXX: begin
                n_mul_a = MUL_W'(r_x);
                n_mul_b = MUL_W'(r_x);
            end
            ST_DET1: begin
                n_mul_a = MUL_W'(r_np);
                n_mul_b = MUL_W'(r_sxx);
            end
            ST_DET2: begin
                n_mul_a = MUL_W'(r_sx);
                n_mul_b = MUL_W'(r_sx);
            end
            ST_DET3: begin
                n_mul_a = MUL_W'(r_np);
                n_mul_b = MUL_W'(r_sxy);
            end
            ST_SLP: begin
                n_mul_a = MUL_W'(r_sx);
                n_mul_b = MUL_W'(r_sy);
            end
            ST_NUM1: begin
                n_mul_a = MUL_W'(n_amp7);
                n_mul_b = MUL_W'(r_np);
            end
            ST_NUM3: begin
                n_mul_a = r_t1;
                n_mul_b = r_det;
            end
            ST_NUM4: begin
                n_mul_a = MUL_W'(n_sx20);
                n_mul_b = r_slope;
            end
            ST_NUM5: begin
                n_mul_a = n_np20;
                n_mul_b = r_slope;
            end
            default: ;
        endcase
    end

    // rounded quotient with sign, offset removed
    always_comb begin
        n_q = $signed({2'b00, w_quot});
        if (r_neg) n_q = -n_q;
        n_q = n_q - (DIV_W+2)'(TIME_OFFSET);
    end

    // sample RAM: write during load, registered read
    always_ff @(posedge i_clk) begin
        if (n_store) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_item.sample_value;
        end
        r_rd <= r_mem[n_raddr];
    end

    // shared multiplier, registered product
    always_ff @(posedge i_clk) begin
        r_prod <= n_mul_a * n_mul_b;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ped_en    <= 1'b0;
            r_presample <= '0;
            r_floor     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PED_EN:    r_ped_en    <= i_cfg_data[0];
                CFG_PRESAMPLE: r_presample <= i_cfg_data[6:0];
                CFG_AMP_FLOOR: r_floor     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_peak      <= '0;
            r_rep       <= '0;
            r_ped_seen  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // ST_OUT reloads the result register itself
            if (r_out_valid && !i_stall && r_state != ST_OUT) r_out_valid <= 1'b0;
            unique case (r_state)
                ST_LOAD: begin
                    if (n_store) begin
                        r_count <= r_count + 1'b1;
                        if (i_item.sample_value > r_peak) begin
                            r_peak <= i_item.sample_value;
                            r_rep  <= 7'd1;
                        end else if (i_item.sample_value == r_peak && r_rep != 7'd127) begin
                            r_rep <= r_rep + 1'b1;
                        end
                        if (r_ped_en && r_ped_seen < r_presample)
                            r_ped_seen <= r_ped_seen + 1'b1;
                    end
                    if (n_accept && i_item.last_sample) r_state <= ST_EVAL;
                end
                ST_EVAL: begin
                    r_res_time <= NO_TIME_Q88;
                    r_amp      <= '0;
                    r_ovf      <= 1'b0;
                    r_pos      <= r_count;
                    if (r_count == '0) begin
                        r_res_status <= STAT_EMPTY;
                        r_state      <= ST_OUT;
                    end else if (r_ped_en && r_ped_seen == '0) begin
                        r_res_status <= STAT_BAD_PED;
                        r_state      <= ST_OUT;
                    end else begin
                        r_amp        <= n_amp;
                        r_ovf        <= n_ovf;
                        r_res_status <= STAT_OK;
                        r_state      <= (n_amp < MIN_TIMED_AMP) ? ST_OUT : ST_SCAN;
                    end
                end
                // walk back from the latest sample while at or under 0.35 of amplitude
                ST_SCAN: begin
                    if (r_pos == '0) begin
                        r_res_status <= STAT_NO_TIME;
                        r_state      <= ST_OUT;
                    end else begin
                        r_state <= ST_SCAN_CHK;
                    end
                end
                ST_SCAN_CHK: begin
                    if (n_s20 <= n_a7) begin
                        r_pos   <= r_pos - 1'b1;
                        r_state <= ST_SCAN;
                    end else if (r_pos == r_count - 1'b1) begin
                        r_res_status <= STAT_NO_TIME;
                        r_state      <= ST_OUT;
                    end else begin
                        r_up      <= $signed(8'(r_pos)) - 8'sd1;
                        r_dn      <= r_pos;
                        r_np      <= '0;
                        r_phase_b <= 1'b0;
                        r_sx      <= '0;
                        r_sy      <= '0;
                        r_sxx     <= '0;
                        r_sxy     <= '0;
                        r_state   <= ST_FIT_SEL;
                    end
                end
                // pick the next fit point, alternating before and after the edge
                ST_FIT_SEL: begin
                    if (!r_phase_b) begin
                        r_idx <= ADDR_W'(r_up);
                        if (!r_up[7]) begin
                            r_state <= ST_FIT_MXY;
                        end else begin
                            r_phase_b <= 1'b1;
                        end
                    end else begin
                        r_idx   <= ADDR_W'(r_dn);
                        r_state <= (r_dn < r_count) ? ST_FIT_MXY : ST_FIT_CHK;
                    end
                end
                ST_FIT_MXY: begin
                    r_x     <= n_x;
                    r_y     <= r_rd;
                    r_state <= ST_FIT_MXX;
                end
                ST_FIT_MXX: begin
                    r_sxy   <= r_sxy + 19'(r_prod);
                    r_state <= ST_FIT_ACC;
                end
                ST_FIT_ACC: begin
                    r_sxx <= r_sxx + 15'(r_prod);
                    r_sx  <= r_sx + 9'(r_x);
                    r_sy  <= r_sy + 13'(r_y);
                    r_np  <= r_np + 1'b1;
                    if (!r_phase_b) begin
                        r_up      <= r_up - 8'sd1;
                        r_phase_b <= 1'b1;
                        r_state   <= ST_FIT_SEL;
                    end else begin
                        r_dn    <= r_dn + 1'b1;
                        r_state <= ST_FIT_CHK;
                    end
                end
                ST_FIT_CHK: begin
                    r_phase_b <= 1'b0;
                    if (r_np < NP_W'(FIT_POINTS) && !(r_dn >= r_count && r_up[7]))
                        r_state <= ST_FIT_SEL;
                    else
                        r_state <= ST_DET1;
                end
                // determinant and slope numerator
                ST_DET1: r_state <= ST_DET2;
                ST_DET2: begin
                    r_tmp   <= MUL_W'(r_prod);
                    r_state <= ST_DET3;
                end
                ST_DET3: begin
                    r_det   <= r_tmp - MUL_W'(r_prod);
                    r_state <= ST_SLP;
                end
                ST_SLP: begin
                    r_tmp   <= MUL_W'(r_prod);
                    r_state <= ST_NUM1;
                end
                ST_NUM1: begin
                    r_slope <= n_slope;
                    if (r_det == '0 || n_slope == '0) begin
                        r_res_status <= STAT_NO_TIME;
                        r_state      <= ST_OUT;
                    end else begin
                        r_state <= ST_NUM2;
                    end
                end
                // crossing numerator and denominator
                ST_NUM2: begin
                    r_t1    <= MUL_W'(r_prod) - $signed(MUL_W'(n_sy20));
                    r_state <= ST_NUM3;
                end
                ST_NUM3: r_state <= ST_NUM4;
                ST_NUM4: begin
                    r_num   <= r_prod;
                    r_state <= ST_NUM5;
                end
                ST_NUM5: begin
                    r_num   <= r_num + r_prod;
                    r_state <= ST_DEN;
                end
                ST_DEN: begin
                    r_neg   <= (n_num < 0);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (w_div_done) r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (n_q > (DIV_W+2)'(32767))
                        r_res_time <= 16'sh7fff;
                    else if (n_q < -(DIV_W+2)'(32768))
                        r_res_time <= -16'sh8000;
                    else
                        r_res_time <= 16'(n_q);
                    r_res_status <= r_ovf ? STAT_OVF : STAT_OK;
                    r_state      <= ST_OUT;
                end
                // hand over to the result register, clear the pulse
                ST_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out.amplitude     <= r_amp;
                        r_out.pulse_time    <= r_res_time;
                        r_out.overflow_seen <= r_ovf;
                        r_out.fit_status    <= r_res_status;
                        r_out_valid         <= 1'b1;
                        r_count             <= '0;
                        r_peak              <= '0;
                        r_rep               <= '0;
                        r_ped_seen          <= '0;
                        r_state             <= ST_LOAD;
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    pat_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign o_stall     = (r_state != ST_LOAD);
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;
    assign o_cfg_ready = 1'b1;

    `ASSERT_IMPLIES(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_SAMPLES), "sample count past capacity")
    `ASSERT_NEXT(a_last_evals, i_clk, i_rst_n, n_accept && i_item.last_sample, r_state == ST_EVAL, "last transfer did not start evaluation")
    `ASSERT_IMPLIES(a_result_from_out, i_clk, i_rst_n, $rose(o_valid), $past(r_state == ST_OUT), "result without hand-over")

endmodule

### src/pat_divider.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pat_pkg (widths) and assert_macros.svh.
module pat_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pat_pkg::DIV_W-1:0] i_dividend,
    input  logic [pat_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [pat_pkg::DIV_W-1:0] o_quotient
);
    import pat_pkg::*;
    `include "assert_macros.svh"

    localparam int STEP_W = $clog2(DIV_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  n_trial;
    logic              n_fit;

    // trial subtract of the next dividend bit
    assign n_trial = {r_rem[DVS_W-2:0], r_quo[DIV_W-1]};
    assign n_fit   = (n_trial >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(DIV_W - 1);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= n_fit ? (n_trial - r_dvs) : n_trial;
                r_quo <= {r_quo[DIV_W-2:0], n_fit};
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    `ASSERT_IMPLIES(a_no_restart, i_clk, i_rst_n, i_start, !r_busy, "divider restarted while busy")
    `ASSERT_IMPLIES(a_done_after_busy, i_clk, i_rst_n, o_done, $past(r_busy), "done without run")
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy, "divider idle after start")

endmodule
